/* design/nrcp_pkg.sv */
// ----------------------------------------------------------------------------
// nrcp_pkg
// shared types and command/status codes for the region cycle profiler
// ----------------------------------------------------------------------------
package nrcp_pkg;

   typedef enum logic [1:0] {
      CMD_BEGIN = 2'd0,
      CMD_END   = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_TABLE_FULL = 3'd1,
      ST_STACK_FULL = 3'd2,
      ST_UNMATCHED  = 3'd3,
      ST_BAD_INDEX  = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [63:0] caller_pc;
      logic [63:0] timestamp;
      logic [6:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [6:0]  slot;
      logic [63:0] site_pc;
      logic [63:0] total_cycles;
      logic [63:0] call_count;
      logic [63:0] peak_cycles;
      logic [7:0]  sites_used;
      logic        overflowed;
      logic [6:0]  open_depth;
   } rsp_type;

endpackage

/* design/nrcp_req_if.sv */
// ----------------------------------------------------------------------------
// nrcp_req_if
// valid/ready channel carrying one command beat
// ----------------------------------------------------------------------------
interface nrcp_req_if;
   logic              valid;
   logic              ready;
   nrcp_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* design/nrcp_rsp_if.sv */
// ----------------------------------------------------------------------------
// nrcp_rsp_if
// valid/ready channel carrying one result beat
// ----------------------------------------------------------------------------
interface nrcp_rsp_if;
   logic              valid;
   logic              ready;
   nrcp_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* design/nested_region_cycle_profiler.sv */
// ----------------------------------------------------------------------------
// nested_region_cycle_profiler
// site table and open-region stack held in synchronous memories
// ----------------------------------------------------------------------------
// begin scans the site table, one site memory read a cycle, then pushes the
// region; end pops it and updates the site record; read fetches one record
// throughput: one command at a time, the next beat is taken the cycle after
// the previous result is loaded; the output register holds a waiting result
// reset clears fill count, depth and overflow flag; memories are not cleared
module nested_region_cycle_profiler #(
   parameter int SITES = 128,
   parameter int DEPTH = 64
) (
   input logic clock,
   input logic reset,
   nrcp_req_if.sink   req,
   nrcp_rsp_if.source rsp
);
   localparam int SW = (SITES > 1) ? $clog2(SITES) : 1;
   localparam int DW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW = $clog2(SITES + 1);
   localparam int PW = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_BEGIN, S_POP, S_END, S_READ, S_OUT
   } state_type;

   // site record memory: pc, total, calls, peak
   logic [255:0]  site_mem [SITES];
   logic [63:0]   start_mem [DEPTH];
   logic [SW-1:0] slot_mem [DEPTH];

   state_type        state_ff;
   nrcp_pkg::req_type cur_ff;
   logic [FW-1:0]    fill_ff;
   logic [PW-1:0]    depth_ff;
   logic             ovf_ff;
   logic [FW-1:0]    scan_ff;     // index being read from site memory
   logic [SW-1:0]    slot_ff;
   logic [255:0]     site_rd_ff;
   logic [63:0]      start_rd_ff;
   logic [SW-1:0]    slot_rd_ff;
   logic             rsp_valid_ff;
   nrcp_pkg::rsp_type rsp_ff;     // result being built
   nrcp_pkg::rsp_type out_ff;     // result beat on the output
   nrcp_pkg::rsp_type out_in;
   logic             out_load;

   // memory access controls
   logic           site_we;
   logic [SW-1:0]  site_wa;
   logic [255:0]   site_wd;
   logic [SW-1:0]  site_ra;
   logic           stk_we;
   logic [DW-1:0]  stk_wa;

   logic [63:0] elapsed;
   logic [63:0] new_total, new_calls, new_peak;

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = out_ff;

   // output register takes a new beat when empty or being drained
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      out_in            = rsp_ff;
      out_in.sites_used = 8'(fill_ff);
      out_in.overflowed = ovf_ff;
      out_in.open_depth = 7'(depth_ff);
   end

   assign elapsed   = cur_ff.timestamp - start_rd_ff;
   assign new_total = site_rd_ff[191:128] + elapsed;
   assign new_calls = site_rd_ff[127:64] + 64'd1;
   assign new_peak  = (elapsed > site_rd_ff[63:0]) ? elapsed : site_rd_ff[63:0];

   always_comb begin
      site_ra = scan_ff[SW-1:0];
      if (state_ff == S_END || state_ff == S_POP) site_ra = slot_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (site_we) site_mem[site_wa] <= site_wd;
      site_rd_ff <= site_mem[site_ra];
      if (stk_we) begin
         start_mem[stk_wa] <= cur_ff.timestamp;
         slot_mem[stk_wa]  <= slot_ff;
      end
      start_rd_ff <= start_mem[DW'(depth_ff - PW'(1))];
      slot_rd_ff  <= slot_mem[DW'(depth_ff - PW'(1))];
   end

   // write controls follow the state machine
   always_comb begin
      site_we = 1'b0;
      site_wa = slot_ff;
      site_wd = {cur_ff.caller_pc, 192'd0};
      stk_we  = 1'b0;
      stk_wa  = DW'(depth_ff);
      if (state_ff == S_END) begin
         site_we = 1'b1;
         site_wa = slot_rd_ff;
         site_wd = {site_rd_ff[255:192], new_total, new_calls, new_peak};
      end else if (state_ff == S_BEGIN) begin
         site_we = (slot_ff == SW'(fill_ff)) && (fill_ff < FW'(SITES))
                   && !(scan_ff < fill_ff);
         stk_we  = depth_ff < PW'(DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         depth_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         scan_ff      <= '0;
      end else begin
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  cur_ff  <= req.data;
                  scan_ff <= '0;
                  rsp_ff  <= '0;
                  unique case (nrcp_pkg::cmd_type'(req.data.cmd))
                     nrcp_pkg::CMD_BEGIN: state_ff <= S_SCAN;
                     nrcp_pkg::CMD_END:   state_ff <= S_POP;
                     nrcp_pkg::CMD_CLEAR: begin
                        fill_ff  <= '0;
                        depth_ff <= '0;
                        ovf_ff   <= 1'b0;
                        state_ff <= S_OUT;
                     end
                     default: begin
                        scan_ff  <= FW'(req.data.read_index);
                        state_ff <= S_READ;
                     end
                  endcase
               end
            end
            // site_rd_ff holds entry scan_ff-1 once scan_ff is nonzero
            S_SCAN: begin
               if (scan_ff != '0 && site_rd_ff[255:192] == cur_ff.caller_pc) begin
                  // hit: keep the record now, the next read moves on
                  slot_ff             <= SW'(scan_ff - FW'(1));
                  scan_ff             <= '0;
                  rsp_ff.site_pc      <= site_rd_ff[255:192];
                  rsp_ff.total_cycles <= site_rd_ff[191:128];
                  rsp_ff.call_count   <= site_rd_ff[127:64];
                  rsp_ff.peak_cycles  <= site_rd_ff[63:0];
                  state_ff            <= S_BEGIN;
               end else if (scan_ff >= fill_ff) begin
                  if (fill_ff >= FW'(SITES)) begin
                     ovf_ff        <= 1'b1;
                     rsp_ff.status <= nrcp_pkg::ST_TABLE_FULL;
                     state_ff      <= S_OUT;
                  end else begin
                     scan_ff  <= fill_ff;
                     slot_ff  <= SW'(fill_ff);
                     state_ff <= S_BEGIN;
                  end
               end else begin
                  scan_ff <= scan_ff + FW'(1);
               end
            end
            // scan_ff == fill_ff marks a new allocation, zero marks a hit
            S_BEGIN: begin
               if (site_we) begin
                  fill_ff <= fill_ff + FW'(1);
                  rsp_ff.site_pc <= cur_ff.caller_pc;
               end
               rsp_ff.slot <= 7'(slot_ff);
               if (depth_ff < PW'(DEPTH)) depth_ff <= depth_ff + PW'(1);
               else rsp_ff.status <= nrcp_pkg::ST_STACK_FULL;
               state_ff <= S_OUT;
            end
            S_POP: begin
               if (depth_ff == '0) begin
                  rsp_ff.status <= nrcp_pkg::ST_UNMATCHED;
                  state_ff      <= S_OUT;
               end else begin
                  state_ff <= (scan_ff == '0) ? S_POP : S_END;
                  scan_ff  <= FW'(1);
               end
            end
            S_END: begin
               depth_ff            <= depth_ff - PW'(1);
               rsp_ff.slot         <= 7'(slot_rd_ff);
               rsp_ff.site_pc      <= site_rd_ff[255:192];
               rsp_ff.total_cycles <= new_total;
               rsp_ff.call_count   <= new_calls;
               rsp_ff.peak_cycles  <= new_peak;
               state_ff            <= S_OUT;
            end
            S_READ: begin
               // wait for the registered read before using site_rd_ff
               if (scan_ff[0] == cur_ff.read_index[0] && cur_ff.cmd[0]) begin
                  cur_ff.cmd <= nrcp_pkg::CMD_CLEAR;
               end else begin
                  rsp_ff.slot <= cur_ff.read_index;
                  if (FW'(cur_ff.read_index) < fill_ff && 32'(cur_ff.read_index) < SITES)
                  begin
                     rsp_ff.site_pc      <= site_rd_ff[255:192];
                     rsp_ff.total_cycles <= site_rd_ff[191:128];
                     rsp_ff.call_count   <= site_rd_ff[127:64];
                     rsp_ff.peak_cycles  <= site_rd_ff[63:0];
                  end else begin
                     rsp_ff.status <= nrcp_pkg::ST_BAD_INDEX;
                  end
                  state_ff <= S_OUT;
               end
            end
            default: begin
               // wait here while the output register still holds a beat
               if (out_load) begin
                  out_ff   <= out_in;
                  state_ff <= S_IDLE;
               end
            end
         endcase
      end
   end
endmodule
